// ===== rtl/touch_tap_detector_macros.svh =====
// ----------------------------------------------------------------------------
// Touch tap detector assertion macros
// Shared concurrent assertion forms for the tap detector checkers.
// ----------------------------------------------------------------------------
`ifndef TOUCH_TAP_DETECTOR_MACROS_SVH
`define TOUCH_TAP_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ttd_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch tap detector package
// Types, field widths and constants shared by the tap detector modules.
// ----------------------------------------------------------------------------
package ttd_pkg;

    localparam int COORD_W    = 12;
    localparam int GESTURE_W  = 8;
    localparam int LEVEL_W    = 4;
    localparam int WINDOW_W   = 8;
    localparam int CLICK_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    localparam logic [COORD_W-1:0] BOX_LOW_RESET = 12'd1000;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 4'hF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX_SAMPLES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_TIMEOUT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JITTER_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_TAP_CODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_TAP_CODE = 3'd4;

    // Click counts.
    localparam logic [CLICK_W-1:0] CLICK_NONE   = 2'd0;
    localparam logic [CLICK_W-1:0] CLICK_SINGLE = 2'd1;
    localparam logic [CLICK_W-1:0] CLICK_DOUBLE = 2'd2;

    typedef struct packed {
        logic [LEVEL_W-1:0]   tap_max_samples;
        logic [WINDOW_W-1:0]  tap_timeout;
        logic [COORD_W-1:0]   jitter_limit;
        logic [GESTURE_W-1:0] single_tap_code;
        logic [GESTURE_W-1:0] double_tap_code;
    } ttd_cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0]   pos_y;
        logic [COORD_W-1:0]   pos_x;
        logic                 finger_down;
        logic [GESTURE_W-1:0] chip_gesture;
    } ttd_sample_t;

    typedef struct packed {
        logic                 gesture_valid;
        logic [GESTURE_W-1:0] gesture_out;
        logic                 touched;
        logic [COORD_W-1:0]   out_y;
        logic [COORD_W-1:0]   out_x;
    } ttd_result_t;

endpackage

// ===== rtl/ttd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Tap detector configuration registers
// Holds the five tuning registers written through the plain write port.
// ----------------------------------------------------------------------------
module ttd_cfg_regs
    import ttd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output ttd_cfg_t              cfg
);

    ttd_cfg_t cfg_reg;
    ttd_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TAP_MAX_SAMPLES: cfg_next.tap_max_samples = cfg_wdata[LEVEL_W-1:0];
                CFG_TAP_TIMEOUT:     cfg_next.tap_timeout     = cfg_wdata[WINDOW_W-1:0];
                CFG_JITTER_LIMIT:    cfg_next.jitter_limit    = cfg_wdata[COORD_W-1:0];
                CFG_SINGLE_TAP_CODE: cfg_next.single_tap_code = cfg_wdata[GESTURE_W-1:0];
                CFG_DOUBLE_TAP_CODE: cfg_next.double_tap_code = cfg_wdata[GESTURE_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tap_max_samples <= 4'd5;
            cfg_reg.tap_timeout     <= 8'd40;
            cfg_reg.jitter_limit    <= 12'd10;
            cfg_reg.single_tap_code <= 8'd5;
            cfg_reg.double_tap_code <= 8'd11;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/ttd_tap_logic.sv =====
// ----------------------------------------------------------------------------
// Tap detector update logic
// Touch level, contact box, tap window and gesture hold state, updated once
// per sample, with the result formed in the same pass.
// ----------------------------------------------------------------------------
module ttd_tap_logic
    import ttd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  ttd_sample_t sample,
    input  ttd_cfg_t    cfg,
    output ttd_result_t result
);

    logic [LEVEL_W-1:0]   level_reg,      level_next;
    logic [LEVEL_W-1:0]   prev_level_reg, prev_level_next;
    logic [COORD_W-1:0]   box_x_low_reg,  box_x_low_next;
    logic [COORD_W-1:0]   box_x_high_reg, box_x_high_next;
    logic [COORD_W-1:0]   box_y_low_reg,  box_y_low_next;
    logic [COORD_W-1:0]   box_y_high_reg, box_y_high_next;
    logic [WINDOW_W-1:0]  window_reg,     window_next;
    logic [CLICK_W-1:0]   click_reg,      click_next;
    logic [GESTURE_W-1:0] held_reg,       held_next;

    logic [COORD_W:0] spread_x;
    logic [COORD_W:0] spread_y;
    logic             x_ok;
    logic             y_ok;
    logic             last_release;
    logic             short_release;
    logic             no_gesture;

    always_comb
    begin
        // Saturating touch level.
        level_next = level_reg;
        if (sample.finger_down && (level_reg != LEVEL_MAX))
        begin
            level_next = level_reg + 4'd1;
        end
        else if (!sample.finger_down && (level_reg != '0))
        begin
            level_next = level_reg - 4'd1;
        end

        // Widen the contact box while a finger is down.
        box_x_low_next  = box_x_low_reg;
        box_x_high_next = box_x_high_reg;
        box_y_low_next  = box_y_low_reg;
        box_y_high_next = box_y_high_reg;
        if (sample.finger_down)
        begin
            if (sample.pos_x < box_x_low_reg)  box_x_low_next  = sample.pos_x;
            if (sample.pos_x > box_x_high_reg) box_x_high_next = sample.pos_x;
            if (sample.pos_y < box_y_low_reg)  box_y_low_next  = sample.pos_y;
            if (sample.pos_y > box_y_high_reg) box_y_high_next = sample.pos_y;
        end

        // The tap window only runs once started and until it reaches the timeout.
        window_next = window_reg;
        if ((window_reg < cfg.tap_timeout) && (window_reg != '0))
        begin
            window_next = window_reg + 8'd1;
        end

        // Spreads are signed: a cleared box (low above high) is in range.
        spread_x = {1'b0, box_x_high_next} - {1'b0, box_x_low_next};
        spread_y = {1'b0, box_y_high_next} - {1'b0, box_y_low_next};
        x_ok     = $signed(spread_x) < $signed({1'b0, cfg.jitter_limit});
        y_ok     = $signed(spread_y) < $signed({1'b0, cfg.jitter_limit});

        no_gesture    = (sample.chip_gesture == '0);
        last_release  = (level_next == '0) && (prev_level_reg == 4'd1);
        short_release = (prev_level_reg > level_next)
                        && (level_next <= cfg.tap_max_samples);

        click_next = click_reg;
        if (last_release)
        begin
            box_x_low_next  = BOX_LOW_RESET;
            box_x_high_next = '0;
            box_y_low_next  = BOX_LOW_RESET;
            box_y_high_next = '0;
        end
        else if (short_release)
        begin
            if (no_gesture && x_ok && y_ok)
            begin
                click_next = CLICK_SINGLE;
                if (window_next > {2'b00, cfg.tap_timeout[WINDOW_W-1:2]})
                begin
                    click_next = CLICK_DOUBLE;
                end
                if (window_next == '0)
                begin
                    window_next = 8'd1;
                end
            end
        end
        else
        begin
            click_next = CLICK_NONE;
        end

        // Gesture hold: the controller's code wins, then a detected tap.
        held_next = held_reg;
        if (!no_gesture)
        begin
            held_next = sample.chip_gesture;
        end
        else if (click_next == CLICK_SINGLE)
        begin
            held_next = cfg.single_tap_code;
        end
        else if (click_next == CLICK_DOUBLE)
        begin
            held_next = cfg.double_tap_code;
        end

        result.out_x         = sample.pos_x;
        result.out_y         = sample.pos_y;
        result.touched       = sample.finger_down;
        result.gesture_valid = (level_next != '0);
        result.gesture_out   = (level_next != '0) ? held_next : '0;

        // Window expiry takes effect after the result is formed.
        if (window_next == cfg.tap_timeout)
        begin
            window_next     = '0;
            click_next      = CLICK_NONE;
            box_x_low_next  = BOX_LOW_RESET;
            box_x_high_next = '0;
            box_y_low_next  = BOX_LOW_RESET;
            box_y_high_next = '0;
        end

        prev_level_next = level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= '0;
            prev_level_reg <= '0;
            box_x_low_reg  <= BOX_LOW_RESET;
            box_x_high_reg <= '0;
            box_y_low_reg  <= BOX_LOW_RESET;
            box_y_high_reg <= '0;
            window_reg     <= '0;
            click_reg      <= CLICK_NONE;
            held_reg       <= '0;
        end
        else if (step)
        begin
            level_reg      <= level_next;
            prev_level_reg <= prev_level_next;
            box_x_low_reg  <= box_x_low_next;
            box_x_high_reg <= box_x_high_next;
            box_y_low_reg  <= box_y_low_next;
            box_y_high_reg <= box_y_high_next;
            window_reg     <= window_next;
            click_reg      <= click_next;
            held_reg       <= held_next;
        end
    end

endmodule

// ===== rtl/touch_tap_detector.sv =====
// ----------------------------------------------------------------------------
// Touch tap detector
// Turns polled touch samples into coordinates plus a held gesture code,
// detecting single and double taps from short, stationary releases.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_*       in         one touch sample: gesture code, finger flag, x, y
//  m_*       out        one result: x, y, finger flag, held gesture, valid
//  cfg_*     in         register write: index, data (no read-back)
//
//  Every input beat yields exactly one output beat, in order.
//  Sustained rate is one beat per cycle while m_tready stays high. An accepted
//  beat sits in the input register and is loaded into the result register
//  once that register is free or being emptied, which raises m_tvalid.
//  The sample state (level, box, tap window, click count, held gesture) is
//  updated in the same cycle the result register loads, so consecutive
//  samples see each other's effect without bubbles.
//  When m_tready is low the result holds and the input register still takes
//  one more beat; s_tready then drops until the result is taken.
//  rst_n is asynchronous and active low; it restores the valid flags, the
//  tap state and the registers to their defaults. Payload holding registers
//  are not reset.
//
module touch_tap_detector
    import ttd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [7:0] chip_gesture, [8] finger_down, [20:9] pos_x, [32:21] pos_y, [39:33] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [11:0] out_x, [23:12] out_y, [24] touched, [32:25] gesture_out,
    // [33] gesture_valid, [39:34] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    ttd_cfg_t    cfg;
    ttd_sample_t in_sample_reg, in_sample_next;
    logic        in_valid_reg,  in_valid_next;
    ttd_result_t out_result_reg, out_result_next;
    logic        out_valid_reg, out_valid_next;
    ttd_result_t result;
    logic        s_fire;
    logic        step;

    ttd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The held sample is processed whenever the result register is free or
    // is being emptied in this cycle.
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign s_fire   = s_tvalid && s_tready;

    ttd_tap_logic u_tap_logic (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .sample (in_sample_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_sample_next = in_sample_reg;
        if (s_fire)
        begin
            in_valid_next              = 1'b1;
            in_sample_next.chip_gesture = s_tdata[7:0];
            in_sample_next.finger_down  = s_tdata[8];
            in_sample_next.pos_x        = s_tdata[20:9];
            in_sample_next.pos_y        = s_tdata[32:21];
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        if (step)
        begin
            out_valid_next  = 1'b1;
            out_result_next = result;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        in_sample_reg  <= in_sample_next;
        out_result_reg <= out_result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0,
                       out_result_reg.gesture_valid,
                       out_result_reg.gesture_out,
                       out_result_reg.touched,
                       out_result_reg.out_y,
                       out_result_reg.out_x};

endmodule

// ===== rtl/ttd_checker.sv =====
// ----------------------------------------------------------------------------
// Tap detector port checker
// Watches the result channel of the tap detector and checks its contents.
// ----------------------------------------------------------------------------
`include "touch_tap_detector_macros.svh"

module ttd_checker
    import ttd_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `TTD_ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
    `TTD_ASSERT_NEXT(a_hold_data, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata), "result beat changed while stalled")
    `TTD_ASSERT_SAME(a_gesture_zero, clk, rst_n, m_tvalid && !m_tdata[33], m_tdata[32:25] == 8'd0, "gesture code set while not valid")
    `TTD_ASSERT_SAME(a_touch_level, clk, rst_n, m_tvalid && m_tdata[24], m_tdata[33], "finger down but touch level is zero")
    `TTD_ASSERT_SAME(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[39:34] == 6'd0, "result padding bits not zero")

endmodule

bind touch_tap_detector ttd_checker u_ttd_checker (.*);
